// ===== design/avcw_pkg.sv =====
// ----------------------------------------------------------------------------
// avcw_pkg
// Shared types and constants of the aligned view crop window block.
// ----------------------------------------------------------------------------
`default_nettype none

package avcw_pkg;

    localparam int PIX_W      = 14;
    localparam int FRAC_W     = 16;
    localparam int ALIGN      = 8;
    localparam int ALIGN_W    = $clog2(ALIGN);
    localparam int FRAC_REG_W = FRAC_W + 1;
    localparam int OFFS_W     = FRAC_W + 3;
    localparam int INSET_W    = PIX_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OFFS_W;

    localparam int ONE_Q    = 1 << FRAC_W;
    localparam int HALF_Q   = 1 << (FRAC_W - 1);
    localparam int FRAC_MIN = (ONE_Q * 2 + 5) / 10;

    // datapath widths
    localparam int SIZE_W   = PIX_W + 1;
    localparam int PRODF_W  = PIX_W + FRAC_REG_W;
    localparam int PC_W     = OFFS_W + PIX_W + 1;
    localparam int SHIFT_W  = PC_W + 1;
    localparam int PI_W     = INSET_W + PIX_W + 1;
    localparam int A_W      = SHIFT_W + 2;
    localparam int NUM_W    = A_W + PIX_W + 1;
    localparam int DVD_W    = NUM_W - FRAC_W;
    localparam int REM_W    = PIX_W + 1;
    localparam int LANES    = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH_FRAC  = 3'd0,
        REG_HEIGHT_FRAC = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_EXTRA_X     = 3'd3,
        REG_CENTER_Y    = 3'd4,
        REG_INSET_X     = 3'd5,
        REG_INSET_Y     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] view_w;
        logic [PIX_W-1:0] view_h;
        logic [PIX_W-1:0] span_w_in;
        logic [PIX_W-1:0] span_h_in;
        logic [PIX_W-1:0] render_w;
        logic [PIX_W-1:0] render_h;
        logic [PIX_W-1:0] eye_x;
        logic [PIX_W-1:0] eye_y;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] crop_x;
        logic [PIX_W-1:0] crop_y;
        logic [PIX_W-1:0] crop_w;
        logic [PIX_W-1:0] crop_h;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [FRAC_REG_W-1:0]    width_fraction;
        logic [FRAC_REG_W-1:0]    height_fraction;
        logic signed [OFFS_W-1:0] center_x_offset;
        logic signed [OFFS_W-1:0] extra_x_offset;
        logic signed [OFFS_W-1:0] center_y_offset;
        logic signed [INSET_W-1:0] inset_x_pixels;
        logic signed [INSET_W-1:0] inset_y_pixels;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic             zero;
        logic [PIX_W-1:0] eye_x;
        logic [PIX_W-1:0] eye_y;
        logic [PIX_W-1:0] disp_w;
        logic [PIX_W-1:0] disp_h;
        logic [PIX_W-1:0] span_w;
        logic [PIX_W-1:0] span_h;
        logic [PIX_W-1:0] render_w;
        logic [PIX_W-1:0] render_h;
    } t_job;

    // per-axis side data carried along the divider
    typedef struct packed {
        logic              zero;
        logic              neg;
        logic [SIZE_W-1:0] w;
        logic [PIX_W-1:0]  span;
    } t_axis_tag;

endpackage

`default_nettype wire

// ===== design/avcw_if.sv =====
// ----------------------------------------------------------------------------
// avcw channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface avcw_in_if;
    import avcw_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface avcw_out_if;
    import avcw_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface avcw_cfg_if;
    import avcw_pkg::*;
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/aligned_view_crop_window.sv =====
// ----------------------------------------------------------------------------
// aligned_view_crop_window
// Top level: register file, front classifier, job queue and arithmetic back.
// ----------------------------------------------------------------------------
// Takes one item per clock with no gaps: every stage advances together and a
// new item enters each cycle unless the result register is full and not being
// taken, in which case the 4-entry job queue absorbs the front. Latency from
// input beat to result beat is set mainly by the divider of the inset scaling
// (36 stages, one quotient bit each), plus the front register, the queue, six
// arithmetic stages and the result register.
// Register writes are taken at any time and should only be issued while idle.
`default_nettype none

module aligned_view_crop_window (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    avcw_in_if.sink   i_in,
    avcw_out_if.source o_out,
    avcw_cfg_if.sink  i_cfg
);
    import avcw_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job back_job;
    logic back_valid;
    logic back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_fraction  <= FRAC_REG_W'(ONE_Q);
            r_cfg.height_fraction <= FRAC_REG_W'(ONE_Q);
            r_cfg.center_x_offset <= '0;
            r_cfg.extra_x_offset  <= '0;
            r_cfg.center_y_offset <= '0;
            r_cfg.inset_x_pixels  <= '0;
            r_cfg.inset_y_pixels  <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.data.index))
                REG_WIDTH_FRAC: begin
                    r_cfg.width_fraction <= i_cfg.data.value[FRAC_REG_W-1:0];
                end
                REG_HEIGHT_FRAC: begin
                    r_cfg.height_fraction <= i_cfg.data.value[FRAC_REG_W-1:0];
                end
                REG_CENTER_X: begin
                    r_cfg.center_x_offset <= i_cfg.data.value[OFFS_W-1:0];
                end
                REG_EXTRA_X: begin
                    r_cfg.extra_x_offset <= i_cfg.data.value[OFFS_W-1:0];
                end
                REG_CENTER_Y: begin
                    r_cfg.center_y_offset <= i_cfg.data.value[OFFS_W-1:0];
                end
                REG_INSET_X: begin
                    r_cfg.inset_x_pixels <= i_cfg.data.value[INSET_W-1:0];
                end
                REG_INSET_Y: begin
                    r_cfg.inset_y_pixels <= i_cfg.data.value[INSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    avcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    avcw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_job),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_data   (back_job),
        .i_pop_ready  (back_ready)
    );

    avcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .i_job       (back_job),
        .o_job_ready (back_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_origin_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.crop_x[ALIGN_W-1:0] == '0)
                     && (o_out.data.crop_y[ALIGN_W-1:0] == '0))
        else $error("crop origin not aligned");
    a_size_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.crop_w[ALIGN_W-1:0] == '0)
                     && (o_out.data.crop_h[ALIGN_W-1:0] == '0))
        else $error("crop size not aligned");
    a_window_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (({1'b0, o_out.data.crop_x} + {1'b0, o_out.data.crop_w})
                 <= {1'b0, {PIX_W{1'b1}}})
         && (({1'b0, o_out.data.crop_y} + {1'b0, o_out.data.crop_h})
                 <= {1'b0, {PIX_W{1'b1}}}))
        else $error("crop window runs past pixel range");
`endif

endmodule

`default_nettype wire

// ===== design/avcw_front.sv =====
// ----------------------------------------------------------------------------
// avcw_front
// Accepts input beats, resolves span defaults and packing, flags empty views.
// ----------------------------------------------------------------------------
`default_nettype none

module avcw_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    avcw_in_if.sink           i_in,
    output avcw_pkg::t_job    o_job,
    output logic              o_job_valid,
    input  wire logic         i_job_ready
);
    import avcw_pkg::*;

    logic             r_valid;
    t_job             r_job;
    t_job             n_job;
    logic [PIX_W-1:0] span_w;
    logic [PIX_W-1:0] span_h;
    logic             sbs;
    logic             tab;

    assign i_in.ready = !r_valid || i_job_ready;

    always_comb begin
        span_w = (i_in.data.span_w_in == '0) ? i_in.data.view_w : i_in.data.span_w_in;
        span_h = (i_in.data.span_h_in == '0) ? i_in.data.view_h : i_in.data.span_h_in;
        // side-by-side / top-and-bottom packing
        sbs = ({1'b0, span_w} >= {i_in.data.view_w, 1'b0})
           && ({1'b0, span_h} <= ({1'b0, i_in.data.view_h} + SIZE_W'(ALIGN)));
        tab = ({1'b0, span_h} >= {i_in.data.view_h, 1'b0})
           && ({1'b0, span_w} <= ({1'b0, i_in.data.view_w} + SIZE_W'(ALIGN)));
        n_job.zero     = (i_in.data.view_w == '0) || (i_in.data.view_h == '0);
        n_job.eye_x    = i_in.data.eye_x;
        n_job.eye_y    = i_in.data.eye_y;
        n_job.disp_w   = sbs ? i_in.data.view_w : span_w;
        n_job.disp_h   = tab ? i_in.data.view_h : span_h;
        n_job.span_w   = span_w;
        n_job.span_h   = span_h;
        n_job.render_w = i_in.data.render_w;
        n_job.render_h = i_in.data.render_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_job <= n_job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_valid;

endmodule

`default_nettype wire

// ===== design/avcw_queue.sv =====
// ----------------------------------------------------------------------------
// avcw_queue
// Short job queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module avcw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  wire avcw_pkg::t_job i_push_data,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output avcw_pkg::t_job     o_pop_data,
    input  wire logic          i_pop_ready
);
    import avcw_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic [QPTR_W:0]   n_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/avcw_div.sv =====
// ----------------------------------------------------------------------------
// avcw_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module avcw_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [avcw_pkg::DVD_W-1:0] i_dvd [avcw_pkg::LANES],
    input  wire logic [avcw_pkg::PIX_W-1:0] i_dvs [avcw_pkg::LANES],
    input  wire avcw_pkg::t_axis_tag       i_tag [avcw_pkg::LANES],
    output logic                           o_valid,
    output logic [avcw_pkg::DVD_W-1:0]     o_quo [avcw_pkg::LANES],
    output avcw_pkg::t_axis_tag            o_tag [avcw_pkg::LANES]
);
    import avcw_pkg::*;

    localparam int N = DVD_W;

    logic             r_v   [N];
    logic [DVD_W-1:0] r_dvd [N][LANES];
    logic [DVD_W-1:0] r_quo [N][LANES];
    logic [REM_W-2:0] r_rem [N][LANES];
    logic [PIX_W-1:0] r_dvs [N][LANES];
    t_axis_tag        r_tag [N][LANES];

    logic [DVD_W-1:0] n_dvd [N][LANES];
    logic [DVD_W-1:0] n_quo [N][LANES];
    logic [REM_W-2:0] n_rem [N][LANES];
    logic [PIX_W-1:0] n_dvs [N][LANES];
    t_axis_tag        n_tag [N][LANES];

    always_comb begin
        logic [DVD_W-1:0] s_dvd;
        logic [DVD_W-1:0] s_quo;
        logic [REM_W-2:0] s_rem;
        logic [REM_W-1:0] rem_sh;
        logic             ge;
        for (int s = 0; s < N; s++) begin
            for (int a = 0; a < LANES; a++) begin
                if (s == 0) begin
                    s_dvd        = i_dvd[a];
                    s_quo        = '0;
                    s_rem        = '0;
                    n_dvs[s][a]  = i_dvs[a];
                    n_tag[s][a]  = i_tag[a];
                end else begin
                    s_dvd        = r_dvd[s-1][a];
                    s_quo        = r_quo[s-1][a];
                    s_rem        = r_rem[s-1][a];
                    n_dvs[s][a]  = r_dvs[s-1][a];
                    n_tag[s][a]  = r_tag[s-1][a];
                end
                rem_sh = {s_rem, s_dvd[DVD_W-1]};
                ge     = rem_sh >= {1'b0, n_dvs[s][a]};
                n_rem[s][a] = ge ? (REM_W-1)'(rem_sh - {1'b0, n_dvs[s][a]})
                                 : rem_sh[REM_W-2:0];
                n_quo[s][a] = {s_quo[DVD_W-2:0], ge};
                n_dvd[s][a] = {s_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < N; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < N; s++) begin
                for (int a = 0; a < LANES; a++) begin
                    r_dvd[s][a] <= n_dvd[s][a];
                    r_quo[s][a] <= n_quo[s][a];
                    r_rem[s][a] <= n_rem[s][a];
                    r_dvs[s][a] <= n_dvs[s][a];
                    r_tag[s][a] <= n_tag[s][a];
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    always_comb begin
        for (int a = 0; a < LANES; a++) begin
            o_quo[a] = r_quo[N-1][a];
            o_tag[a] = r_tag[N-1][a];
        end
    end

endmodule

`default_nettype wire

// ===== design/avcw_back.sv =====
// ----------------------------------------------------------------------------
// avcw_back
// Pipelined size, centre and inset arithmetic, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module avcw_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire avcw_pkg::t_job i_job,
    output logic            o_job_ready,
    input  wire avcw_pkg::t_cfg i_cfg,
    avcw_out_if.source      o_out
);
    import avcw_pkg::*;

    logic adv;
    logic r_out_valid;
    t_out_item r_out;

    // lane view of the job (0 = x, 1 = y)
    logic [PIX_W-1:0]        l_eye [LANES];
    logic [PIX_W-1:0]        l_disp [LANES];
    logic [PIX_W-1:0]        l_span [LANES];
    logic [PIX_W-1:0]        l_rend [LANES];
    logic [FRAC_REG_W-1:0]   l_frac [LANES];
    logic signed [OFFS_W-1:0] l_c [LANES];
    logic signed [OFFS_W-1:0] l_e [LANES];
    logic signed [INSET_W-1:0] l_ins [LANES];

    // stage 1
    logic r_s1_v, r_s1_zero;
    logic [PIX_W-1:0]         r_s1_eye [LANES], r_s1_disp [LANES];
    logic [PIX_W-1:0]         r_s1_span [LANES], r_s1_rend [LANES];
    logic [PRODF_W-1:0]       r_s1_wf [LANES], n_s1_wf [LANES];
    logic signed [PC_W-1:0]   r_s1_pc [LANES], n_s1_pc [LANES];
    logic signed [PC_W-1:0]   r_s1_pe [LANES], n_s1_pe [LANES];
    logic signed [PI_W-1:0]   r_s1_pi [LANES], n_s1_pi [LANES];
    // stage 2
    logic r_s2_v, r_s2_zero;
    logic [PIX_W-1:0]         r_s2_eye [LANES], r_s2_disp [LANES];
    logic [PIX_W-1:0]         r_s2_span [LANES], r_s2_rend [LANES];
    logic [SIZE_W-1:0]        r_s2_w [LANES], n_s2_w [LANES];
    logic signed [SHIFT_W-1:0] r_s2_sh [LANES], n_s2_sh [LANES];
    logic signed [PI_W-1:0]   r_s2_pi [LANES];
    // stage 3
    logic r_s3_v, r_s3_zero;
    logic signed [A_W-1:0]    r_s3_a [LANES], n_s3_a [LANES];
    logic [SIZE_W-1:0]        r_s3_w [LANES];
    logic [PIX_W-1:0]         r_s3_span [LANES], r_s3_r [LANES], n_s3_r [LANES];
    logic signed [PI_W-1:0]   r_s3_pi [LANES];
    // stage 4
    logic r_s4_v, r_s4_zero;
    logic signed [NUM_W-1:0]  r_s4_p [LANES], n_s4_p [LANES];
    logic [SIZE_W-1:0]        r_s4_w [LANES];
    logic [PIX_W-1:0]         r_s4_span [LANES], r_s4_r [LANES];
    logic signed [PI_W-1:0]   r_s4_pi [LANES];
    // stage 5
    logic r_s5_v, r_s5_zero;
    logic signed [NUM_W-1:0]  r_s5_num [LANES], n_s5_num [LANES];
    logic [SIZE_W-1:0]        r_s5_w [LANES];
    logic [PIX_W-1:0]         r_s5_span [LANES], r_s5_r [LANES];
    // stage 6
    logic r_s6_v;
    logic [DVD_W-1:0]         r_s6_d [LANES], n_s6_d [LANES];
    logic [PIX_W-1:0]         r_s6_r [LANES];
    t_axis_tag                r_s6_tag [LANES], n_s6_tag [LANES];
    // divider out
    logic                     dv_valid;
    logic [DVD_W-1:0]         dv_quo [LANES];
    t_axis_tag                dv_tag [LANES];
    logic [PIX_W-1:0]         n_org [LANES];
    logic [PIX_W-1:0]         n_len [LANES];
    t_out_item                n_out;

    assign adv         = !r_out_valid || o_out.ready;
    assign o_job_ready = adv;

    always_comb begin
        l_eye[0]  = i_job.eye_x;     l_eye[1]  = i_job.eye_y;
        l_disp[0] = i_job.disp_w;    l_disp[1] = i_job.disp_h;
        l_span[0] = i_job.span_w;    l_span[1] = i_job.span_h;
        l_rend[0] = i_job.render_w;  l_rend[1] = i_job.render_h;
        l_frac[0] = i_cfg.width_fraction;
        l_frac[1] = i_cfg.height_fraction;
        l_c[0]    = i_cfg.center_x_offset;
        l_c[1]    = i_cfg.center_y_offset;
        l_e[0]    = i_cfg.extra_x_offset;
        l_e[1]    = '0;
        l_ins[0]  = i_cfg.inset_x_pixels;
        l_ins[1]  = i_cfg.inset_y_pixels;
    end

    // stage 1: products for size, shift and inset
    always_comb begin
        logic [FRAC_REG_W-1:0] f;
        logic [PIX_W-1:0]      sp;
        for (int a = 0; a < LANES; a++) begin
            f = l_frac[a];
            if (f < FRAC_REG_W'(FRAC_MIN)) begin
                f = FRAC_REG_W'(FRAC_MIN);
            end
            if (f > FRAC_REG_W'(ONE_Q)) begin
                f = FRAC_REG_W'(ONE_Q);
            end
            sp = (l_rend[a] == '0) ? PIX_W'(1) : l_span[a];
            n_s1_wf[a] = PRODF_W'(l_disp[a]) * PRODF_W'(f);
            n_s1_pc[a] = l_c[a] * $signed({1'b0, l_span[a]});
            n_s1_pe[a] = l_e[a] * $signed({1'b0, l_disp[a]});
            n_s1_pi[a] = l_ins[a] * $signed({1'b0, sp});
        end
    end

    // stage 2: round and align size, total shift
    always_comb begin
        logic [PRODF_W:0]  wsum;
        logic [SIZE_W-1:0] w;
        for (int a = 0; a < LANES; a++) begin
            wsum = {1'b0, r_s1_wf[a]} + (PRODF_W+1)'(HALF_Q);
            w    = SIZE_W'(wsum >> FRAC_W);
            w    = (w + SIZE_W'(ALIGN - 1)) & ~SIZE_W'(ALIGN - 1);
            if (w < SIZE_W'(ALIGN)) begin
                w = SIZE_W'(ALIGN);
            end
            if (w > {1'b0, r_s1_span[a]}) begin
                w = {1'b0, r_s1_span[a]} & ~SIZE_W'(ALIGN - 1);
            end
            n_s2_w[a]  = w;
            n_s2_sh[a] = SHIFT_W'(r_s1_pc[a]) + SHIFT_W'(r_s1_pe[a]);
        end
    end

    // stage 3: window start numerator in Q.FRAC units
    always_comb begin
        for (int a = 0; a < LANES; a++) begin
            n_s3_a[a] = $signed({{(A_W-PIX_W-FRAC_W){1'b0}}, r_s2_eye[a], {FRAC_W{1'b0}}})
                      + $signed({{(A_W-PIX_W-FRAC_W+1){1'b0}}, r_s2_disp[a],
                                 {(FRAC_W-1){1'b0}}})
                      + A_W'(r_s2_sh[a])
                      - $signed({{(A_W-SIZE_W-FRAC_W+1){1'b0}}, r_s2_w[a],
                                 {(FRAC_W-1){1'b0}}});
            n_s3_r[a] = (r_s2_rend[a] == '0) ? PIX_W'(1) : r_s2_rend[a];
        end
    end

    // stage 4: scale by render size
    always_comb begin
        for (int a = 0; a < LANES; a++) begin
            n_s4_p[a] = r_s3_a[a] * $signed({1'b0, r_s3_r[a]});
        end
    end

    // stage 5: add inset term
    always_comb begin
        for (int a = 0; a < LANES; a++) begin
            n_s5_num[a] = r_s4_p[a] + (NUM_W'(r_s4_pi[a]) <<< FRAC_W);
        end
    end

    // stage 6: magnitude plus half divisor, pre-shifted for the divider
    always_comb begin
        logic [NUM_W-1:0] m;
        logic [NUM_W-1:0] ms;
        for (int a = 0; a < LANES; a++) begin
            m  = r_s5_num[a][NUM_W-1] ? NUM_W'(-r_s5_num[a]) : NUM_W'(r_s5_num[a]);
            ms = m + (NUM_W'(r_s5_r[a]) << (FRAC_W - 1));
            n_s6_d[a]        = ms[NUM_W-1:FRAC_W];
            n_s6_tag[a].zero = r_s5_zero;
            n_s6_tag[a].neg  = r_s5_num[a][NUM_W-1];
            n_s6_tag[a].w    = r_s5_w[a];
            n_s6_tag[a].span = r_s5_span[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_job_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_zero <= i_job.zero;
            r_s2_zero <= r_s1_zero;
            r_s3_zero <= r_s2_zero;
            r_s4_zero <= r_s3_zero;
            r_s5_zero <= r_s4_zero;
            for (int a = 0; a < LANES; a++) begin
                r_s1_eye[a]  <= l_eye[a];
                r_s1_disp[a] <= l_disp[a];
                r_s1_span[a] <= l_span[a];
                r_s1_rend[a] <= l_rend[a];
                r_s1_wf[a]   <= n_s1_wf[a];
                r_s1_pc[a]   <= n_s1_pc[a];
                r_s1_pe[a]   <= n_s1_pe[a];
                r_s1_pi[a]   <= n_s1_pi[a];

                r_s2_eye[a]  <= r_s1_eye[a];
                r_s2_disp[a] <= r_s1_disp[a];
                r_s2_span[a] <= r_s1_span[a];
                r_s2_rend[a] <= r_s1_rend[a];
                r_s2_w[a]    <= n_s2_w[a];
                r_s2_sh[a]   <= n_s2_sh[a];
                r_s2_pi[a]   <= r_s1_pi[a];

                r_s3_a[a]    <= n_s3_a[a];
                r_s3_w[a]    <= r_s2_w[a];
                r_s3_span[a] <= r_s2_span[a];
                r_s3_r[a]    <= n_s3_r[a];
                r_s3_pi[a]   <= r_s2_pi[a];

                r_s4_p[a]    <= n_s4_p[a];
                r_s4_w[a]    <= r_s3_w[a];
                r_s4_span[a] <= r_s3_span[a];
                r_s4_r[a]    <= r_s3_r[a];
                r_s4_pi[a]   <= r_s3_pi[a];

                r_s5_num[a]  <= n_s5_num[a];
                r_s5_w[a]    <= r_s4_w[a];
                r_s5_span[a] <= r_s4_span[a];
                r_s5_r[a]    <= r_s4_r[a];

                r_s6_d[a]    <= n_s6_d[a];
                r_s6_r[a]    <= r_s5_r[a];
                r_s6_tag[a]  <= n_s6_tag[a];
            end
        end
    end

    avcw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s6_v),
        .i_dvd   (r_s6_d),
        .i_dvs   (r_s6_r),
        .i_tag   (r_s6_tag),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    // origin: aligned down, floored at zero, pulled back into the span
    always_comb begin
        logic [DVD_W-1:0] o;
        logic [DVD_W:0]   end_pos;
        for (int a = 0; a < LANES; a++) begin
            o = dv_tag[a].neg ? '0 : (dv_quo[a] & ~DVD_W'(ALIGN - 1));
            end_pos = (DVD_W+1)'(o) + (DVD_W+1)'(dv_tag[a].w);
            if (end_pos > (DVD_W+1)'(dv_tag[a].span)) begin
                o = DVD_W'(({1'b0, dv_tag[a].span} - dv_tag[a].w)
                           & ~SIZE_W'(ALIGN - 1));
            end
            n_org[a] = dv_tag[a].zero ? '0 : o[PIX_W-1:0];
            n_len[a] = dv_tag[a].zero ? '0 : dv_tag[a].w[PIX_W-1:0];
        end
        n_out.crop_x = n_org[0];
        n_out.crop_y = n_org[1];
        n_out.crop_w = n_len[0];
        n_out.crop_h = n_len[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && dv_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire
